### sv/rrsm_pkg.sv
// rrsm_pkg: shared types and constants for the reserved region table
// depends on nothing; imported by rrsm_dp, rrsm_ctrl and the top level
package rrsm_pkg;

	// table geometry
	localparam int MAX_REGIONS = 32;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int ADDR_W      = 64;
	localparam int TOTAL_W     = 6;

	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_REGIONS);
	localparam logic [ADDR_W-1:0] ALL_ONES = '1;

	// request commands
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_SORT  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// one table entry
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] limit;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_ADD,
		OP_CLEAR,
		OP_RD_FIRST,
		OP_MRG_FIRST,
		OP_LD_FIRST,
		OP_RD_NEXT,
		OP_SORT_CMP,
		OP_SORT_END,
		OP_MRG_STEP,
		OP_MRG_END,
		OP_QRY_RD,
		OP_QRY_SEL,
		OP_QRY_STEP
	} dp_op_t;

	// what goes into the output register
	typedef enum logic [1:0] {
		PUSH_NONE,
		PUSH_DONE,
		PUSH_GAP,
		PUSH_GAP_LAST
	} push_t;

	typedef struct packed {
		dp_op_t op;
		push_t  push;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic count_lt2;
		logic j_last;
		logic pass_last;
		logic q_found;
		logic q_brk;
		logic pend_v;
		logic out_space;
	} dp_stat_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_RESP,
		S_SORT_RD0,
		S_SORT_LD0,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_END,
		S_MRG_RD0,
		S_MRG_LD0,
		S_MRG_RD,
		S_MRG_STEP,
		S_MRG_END,
		S_QRY_RD,
		S_QRY_SEL,
		S_QRY_STEP,
		S_QRY_FIN
	} state_t;

endpackage

### sv/rrsm_ram.sv
// rrsm_ram: generic single write port, single read port ram
// registered read data; no package dependency
module rrsm_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/rrsm_dp.sv
// rrsm_dp: datapath of the reserved region table: table ram, sort/merge
// and query registers, compares and the output register; uses rrsm_pkg, rrsm_ram
module rrsm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrsm_pkg::ctrl_cmd_t           ctl,
	output rrsm_pkg::dp_stat_t            stat,
	input  logic [1:0]                    command,
	input  logic [rrsm_pkg::ADDR_W-1:0]   addr_lo,
	input  logic [rrsm_pkg::ADDR_W-1:0]   addr_hi,
	input  logic                          cfg_wr_en,
	input  logic [rrsm_pkg::ADDR_W-1:0]   cfg_wr_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [rrsm_pkg::ADDR_W-1:0]   gap_start,
	output logic [rrsm_pkg::ADDR_W-1:0]   gap_end,
	output logic                          gap_valid,
	output logic [rrsm_pkg::TOTAL_W-1:0]  entry_total,
	output logic                          status,
	output logic                          last
);
	import rrsm_pkg::*;

	cmd_t              cmd_q;
	logic [ADDR_W-1:0] start_q, end_q, lowest_q, prev_q;
	logic [ADDR_W-1:0] gs_q, ge_q, rend_q, pend_gs_q, pend_ge_q;
	logic [CNT_W-1:0]  count_q, pass_q, i_q;
	logic [IDX_W-1:0]  j_q, w_q;
	logic              full_hit_q, pend_v_q;
	entry_t            cur_q;

	logic [ADDR_W-1:0]  gap_start_q, gap_end_q;
	logic               out_valid_q, gap_valid_q, status_q, last_q;
	logic [TOTAL_W-1:0] total_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	entry_t            ram_wdata, rdata;
	logic [ENTRY_W-1:0] rdata_raw;

	logic              full, swap, sep, in_tab, out_space;
	logic [ADDR_W-1:0] rb, rl;

	// table storage
	rrsm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_tab (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata_raw)
	);
	assign rdata = entry_t'(rdata_raw);

	// compares
	assign full      = (count_q >= MAX_CNT);
	assign swap      = (cur_q.base > rdata.base);
	assign sep       = (rdata.base >= cur_q.limit);
	assign in_tab    = (i_q < count_q);
	assign rb        = in_tab ? rdata.base : ALL_ONES;
	assign rl        = in_tab ? rdata.limit : ALL_ONES;
	assign out_space = !out_valid_q || out_ready;

	// status toward the controller
	always_comb begin
		stat.cmd        = cmd_q;
		stat.count_lt2  = (count_q < CNT_W'(2));
		stat.j_last     = ((CNT_W'(j_q) + CNT_W'(2)) == pass_q);
		stat.pass_last  = (pass_q == CNT_W'(2));
		stat.q_found    = (gs_q < ge_q);
		stat.q_brk      = (ge_q == end_q);
		stat.pend_v     = pend_v_q;
		stat.out_space  = out_space;
	end

	// ram address and write data selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = cur_q;
		ram_raddr = '0;
		case (ctl.op)
			OP_ADD: begin
				ram_we    = !full;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = '{base: start_q, limit: end_q};
			end
			OP_LD_FIRST, OP_RD_NEXT: begin
				ram_raddr = j_q + IDX_W'(1);
			end
			OP_QRY_RD: begin
				ram_raddr = i_q[IDX_W-1:0];
			end
			OP_SORT_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = swap ? rdata : cur_q;
			end
			OP_SORT_END: begin
				ram_we    = 1'b1;
				ram_waddr = IDX_W'(pass_q - CNT_W'(1));
			end
			OP_MRG_STEP: begin
				ram_we    = sep;
				ram_waddr = w_q;
			end
			OP_MRG_END: begin
				ram_we    = 1'b1;
				ram_waddr = w_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers: count, base register, pending flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			lowest_q    <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lowest_q <= cfg_wr_data;
			end
			case (ctl.op)
				OP_ADD: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_CLEAR:    count_q  <= '0;
				OP_MRG_END:  count_q  <= CNT_W'(w_q) + CNT_W'(1);
				OP_ACCEPT:   pend_v_q <= 1'b0;
				OP_QRY_STEP: begin
					if (stat.q_found) begin
						pend_v_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (ctl.push != PUSH_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of sort, merge and query
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ACCEPT: begin
				cmd_q      <= cmd_t'(command);
				start_q    <= addr_lo;
				end_q      <= addr_hi;
				full_hit_q <= 1'b0;
				prev_q     <= lowest_q;
				i_q        <= '0;
				pass_q     <= count_q;
			end
			OP_ADD: begin
				if (full) begin
					full_hit_q <= 1'b1;
				end
			end
			OP_RD_FIRST: j_q <= '0;
			OP_MRG_FIRST: begin
				j_q    <= '0;
				w_q    <= '0;
				pass_q <= count_q;
			end
			OP_LD_FIRST: cur_q <= rdata;
			OP_SORT_CMP: begin
				if (!swap) begin
					cur_q <= rdata;
				end
				j_q <= j_q + IDX_W'(1);
			end
			OP_SORT_END: pass_q <= pass_q - CNT_W'(1);
			OP_MRG_STEP: begin
				if (sep) begin
					w_q   <= w_q + IDX_W'(1);
					cur_q <= rdata;
				end else if (rdata.limit > cur_q.limit) begin
					cur_q.limit <= rdata.limit;
				end
				j_q <= j_q + IDX_W'(1);
			end
			OP_QRY_SEL: begin
				gs_q   <= (start_q > prev_q) ? start_q : prev_q;
				ge_q   <= (end_q < rb) ? end_q : rb;
				rend_q <= rl;
			end
			OP_QRY_STEP: begin
				if (stat.q_found) begin
					pend_gs_q <= gs_q;
					pend_ge_q <= ge_q;
				end
				prev_q <= rend_q;
				i_q    <= i_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		case (ctl.push)
			PUSH_DONE: begin
				gap_start_q <= '0;
				gap_end_q   <= '0;
				gap_valid_q <= 1'b0;
				total_q     <= TOTAL_W'(count_q);
				status_q    <= full_hit_q;
				last_q      <= 1'b1;
			end
			PUSH_GAP, PUSH_GAP_LAST: begin
				gap_start_q <= pend_gs_q;
				gap_end_q   <= pend_ge_q;
				gap_valid_q <= 1'b1;
				total_q     <= TOTAL_W'(count_q);
				status_q    <= 1'b0;
				last_q      <= (ctl.push == PUSH_GAP_LAST);
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign gap_start   = gap_start_q;
	assign gap_end     = gap_end_q;
	assign gap_valid   = gap_valid_q;
	assign entry_total = total_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

### sv/rrsm_ctrl.sv
// rrsm_ctrl: controller state machine of the reserved region table
// sequences add, clear, bubble sort, merge and gap query; uses rrsm_pkg
module rrsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrsm_pkg::dp_stat_t  stat,
	output rrsm_pkg::ctrl_cmd_t ctl
);
	import rrsm_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl.op   = OP_NONE;
		ctl.push = PUSH_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op  = OP_ACCEPT;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.cmd)
					CMD_ADD: begin
						ctl.op  = OP_ADD;
						state_d = S_RESP;
					end
					CMD_CLEAR: begin
						ctl.op  = OP_CLEAR;
						state_d = S_RESP;
					end
					CMD_SORT:  state_d = stat.count_lt2 ? S_RESP : S_SORT_RD0;
					CMD_QUERY: state_d = S_QRY_RD;
					default:   state_d = S_RESP;
				endcase
			end
			S_RESP: begin
				if (stat.out_space) begin
					ctl.push = PUSH_DONE;
					state_d  = S_IDLE;
				end
			end
			// one bubble pass: largest start moves to the end of the pass
			S_SORT_RD0: begin
				ctl.op  = OP_RD_FIRST;
				state_d = S_SORT_LD0;
			end
			S_SORT_LD0: begin
				ctl.op  = OP_LD_FIRST;
				state_d = S_SORT_CMP;
			end
			S_SORT_RD: begin
				ctl.op  = OP_RD_NEXT;
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				ctl.op  = OP_SORT_CMP;
				state_d = stat.j_last ? S_SORT_END : S_SORT_RD;
			end
			S_SORT_END: begin
				ctl.op  = OP_SORT_END;
				state_d = stat.pass_last ? S_MRG_RD0 : S_SORT_RD0;
			end
			// merge: stream through the sorted table, compacting in place
			S_MRG_RD0: begin
				ctl.op  = OP_MRG_FIRST;
				state_d = S_MRG_LD0;
			end
			S_MRG_LD0: begin
				ctl.op  = OP_LD_FIRST;
				state_d = S_MRG_STEP;
			end
			S_MRG_RD: begin
				ctl.op  = OP_RD_NEXT;
				state_d = S_MRG_STEP;
			end
			S_MRG_STEP: begin
				ctl.op  = OP_MRG_STEP;
				state_d = stat.j_last ? S_MRG_END : S_MRG_RD;
			end
			S_MRG_END: begin
				ctl.op  = OP_MRG_END;
				state_d = S_RESP;
			end
			// query: each table entry passes S_QRY_RD, S_QRY_SEL and S_QRY_STEP, gaps held back by one
			S_QRY_RD: begin
				ctl.op  = OP_QRY_RD;
				state_d = S_QRY_SEL;
			end
			S_QRY_SEL: begin
				ctl.op  = OP_QRY_SEL;
				state_d = S_QRY_STEP;
			end
			S_QRY_STEP: begin
				if (!(stat.q_found && stat.pend_v && !stat.out_space)) begin
					ctl.op = OP_QRY_STEP;
					if (stat.q_found && stat.pend_v) begin
						ctl.push = PUSH_GAP;
					end
					state_d = stat.q_brk ? S_QRY_FIN : S_QRY_RD;
				end
			end
			S_QRY_FIN: begin
				if (stat.out_space) begin
					ctl.push = stat.pend_v ? PUSH_GAP_LAST : PUSH_DONE;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### sv/reserved_region_sort_merge_gaps.sv
// reserved_region_sort_merge_gaps: top level of the reserved region table
// joins rrsm_ctrl and rrsm_dp; uses rrsm_pkg
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  in       | in_valid / in_ready       | command, addr_lo, addr_hi
//  out      | out_valid / out_ready     | gap_start, gap_end, gap_valid,
//           |                           | entry_total, status, last
//  cfg      | cfg_wr_en (no wait)       | cfg_wr_data (lowest_address)
//
// add and clear pass S_DISPATCH and S_RESP after the request is taken; sort,
// merge and query read the table one entry at a time through its single read
// port, a query stepping through S_QRY_RD, S_QRY_SEL and S_QRY_STEP per entry.
// one request is worked on at a time; a new request is taken while a result
// still sits in the output register. a full output register stalls a query.
// arst_n clears the entry count, the base register and the output valid;
// the table ram is not cleared, entries beyond the count never reach a result.
module reserved_region_sort_merge_gaps (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [rrsm_pkg::ADDR_W-1:0]   addr_lo,
	input  logic [rrsm_pkg::ADDR_W-1:0]   addr_hi,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rrsm_pkg::ADDR_W-1:0]   gap_start,
	output logic [rrsm_pkg::ADDR_W-1:0]   gap_end,
	output logic                          gap_valid,
	output logic [rrsm_pkg::TOTAL_W-1:0]  entry_total,
	output logic                          status,
	output logic                          last,
	input  logic                          cfg_wr_en,
	input  logic [rrsm_pkg::ADDR_W-1:0]   cfg_wr_data
);
	import rrsm_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// controller
	rrsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath
	rrsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.command     (command),
		.addr_lo     (addr_lo),
		.addr_hi     (addr_hi),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.gap_start   (gap_start),
		.gap_end     (gap_end),
		.gap_valid   (gap_valid),
		.entry_total (entry_total),
		.status      (status),
		.last        (last)
	);

	// entry count never passes the table size
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_total <= TOTAL_W'(MAX_REGIONS)))
		else $error("entry_total beyond table size");

	// full status only with a full table
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (entry_total == TOTAL_W'(MAX_REGIONS)))
		else $error("full status with table not full");

	// a reported gap is never empty
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gap_valid) |-> (gap_start < gap_end))
		else $error("empty gap reported");

	// a result without a gap always closes its request
	a_nogap_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !gap_valid) |-> last)
		else $error("non-gap result without last");

endmodule
